// ===== rtl/dbs_pkg.sv =====
// Shared types and constants for the day-bucket battery statistics block.
// Used by the controller, the datapath and the top level; depends on nothing.
package dbs_pkg;

    // Field widths of the request and result items.
    localparam int MV_W      = 16;
    localparam int DAY_W     = 32;
    localparam int BKT_SUM_W = 40;
    localparam int BKT_CNT_W = 24;

    // A bucket's count stops growing at this value.
    localparam logic [BKT_CNT_W-1:0] BKT_CNT_MAX = {BKT_CNT_W{1'b1}};

    // Request command codes.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Incoming request.
    typedef struct packed {
        logic            cmd;
        logic [MV_W-1:0]  reading_mv;
        logic [DAY_W-1:0] day;
    } t_req;

    // Outgoing result.
    typedef struct packed {
        logic [MV_W-1:0] window_low;
        logic [MV_W-1:0] window_high;
        logic [MV_W-1:0] window_avg;
    } t_res;

    // One bucket of the ring.
    typedef struct packed {
        logic [MV_W-1:0]      low;
        logic [MV_W-1:0]      high;
        logic [BKT_SUM_W-1:0] sum;
        logic [BKT_CNT_W-1:0] count;
        logic [DAY_W-1:0]     day;
    } t_bucket;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV_INIT,
        ST_DIV,
        ST_PUSH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_add;
        logic load_query;
        logic mod_step;
        logic rd_bucket;
        logic wr_bucket;
        logic scan_rd;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_zero;
    } t_dp_sts;

endpackage

// ===== rtl/dbs_ctrl.sv =====
// Controller state machine of the day-bucket statistics block.
// Depends on dbs_pkg; drives the datapath through t_dp_cmd and reads t_dp_sts.
module dbs_ctrl import dbs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_req_cmd,
    input  logic    i_stall,
    input  t_dp_sts i_sts,
    output logic    o_stall,
    output logic    o_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_ovalid;
    logic   n_ovalid;
    logic   out_free;

    // The result register may be refilled when it is empty or being taken.
    assign out_free = !r_ovalid || !i_stall;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_req_cmd == CMD_QUERY) begin
                        o_cmd.load_query = 1'b1;
                        n_state          = ST_SCAN;
                    end else begin
                        o_cmd.load_add = 1'b1;
                        n_state        = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.cnt_zero) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_bucket = 1'b1;
                n_state         = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.wr_bucket = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.cnt_zero) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last bucket read is folded into the totals here.
                n_state = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.cnt_zero) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;

    // A result that was ready to go out must be shown on the next cycle.
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH && out_free) |=> (o_valid && r_state == ST_IDLE))
        else $error("finished result not presented");

endmodule

// ===== rtl/dbs_dp.sv =====
// Datapath of the day-bucket statistics block: bucket memory, day modulo unit,
// scan accumulators and a restoring divider. Depends on dbs_pkg.
module dbs_dp import dbs_pkg::*; #(
    parameter int NUM_BUCKETS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_req    i_req,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output t_res    o_res
);

    localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CNT_W = (IDX_W > 5) ? IDX_W : 5;
    localparam int SUM_W = BKT_SUM_W + IDX_W;
    localparam int TOT_W = BKT_CNT_W + IDX_W;
    localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(2);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(NUM_BUCKETS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(MV_W - 1);
    localparam logic [IDX_W:0]   N_MOD     = (IDX_W + 1)'(NUM_BUCKETS);

    // Day modulo constants: the upper half of the day is folded onto the lower
    // half with weight 2^HALF_W mod N, and the folded value is reduced by an
    // exact reciprocal multiplication.
    localparam int HALF_W = DAY_W / 2;
    localparam int FOLD_W = HALF_W + IDX_W;
    localparam int MUL_W  = FOLD_W + 2;
    localparam int PROD_W = FOLD_W + MUL_W;
    localparam int RCP_SH = FOLD_W + $clog2(NUM_BUCKETS);
    localparam logic [IDX_W-1:0] FOLD_WT = IDX_W'((64'd1 << HALF_W) % NUM_BUCKETS);
    localparam logic [MUL_W-1:0] RCP_M   =
        MUL_W'(((64'd1 << RCP_SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

    // Bucket store and its valid flags.
    t_bucket          mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_valid;

    t_req             r_req;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_rmd;
    logic [IDX_W-1:0] n_rmd;
    t_bucket          r_rd_data;
    logic             r_rd_vld;
    logic             r_acc_en;
    logic [IDX_W-1:0] rd_addr;

    logic [FOLD_W-1:0] r_fold;
    logic [FOLD_W-1:0] n_fold;
    logic [PROD_W-1:0] r_prod;
    logic [FOLD_W-1:0] mod_q;
    logic [FOLD_W-1:0] mod_r;

    logic [MV_W-1:0]  r_lo;
    logic [MV_W-1:0]  r_hi;
    logic [SUM_W-1:0] r_sum;
    logic [TOT_W-1:0] r_tot;
    logic             r_seen;

    logic [TOT_W-1:0] r_rem;
    logic [TOT_W-1:0] n_rem;
    logic [MV_W-1:0]  r_qd;
    logic [MV_W-1:0]  n_qd;
    t_res             r_res;

    logic [TOT_W:0]   div_t;
    logic             div_ge;
    logic             hit;
    t_bucket          upd;

    // Step counter shared by the modulo, scan and divide phases.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load_add) begin
            r_cnt <= MOD_LAST;
        end else if (i_cmd.load_query) begin
            r_cnt <= SCAN_LAST;
        end else if (i_cmd.div_init) begin
            r_cnt <= DIV_LAST;
        end else if (i_cmd.mod_step || i_cmd.scan_rd || i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_sts.cnt_zero = (r_cnt == '0);

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_add || i_cmd.load_query) begin
            r_req <= i_req;
        end
    end

    // Day modulo bucket count: fold, multiply, remainder.
    assign n_fold = FOLD_W'(r_req.day[DAY_W-1:HALF_W]) * FOLD_W'(FOLD_WT)
                  + FOLD_W'(r_req.day[HALF_W-1:0]);
    assign mod_q  = FOLD_W'(r_prod >> RCP_SH);
    assign mod_r  = r_fold - mod_q * FOLD_W'(NUM_BUCKETS);
    assign n_rmd  = mod_r[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_step) begin
            r_fold <= n_fold;
            r_prod <= PROD_W'(r_fold) * PROD_W'(RCP_M);
        end
    end

    // The bucket index is taken only on the last modulo cycle, once fold and
    // product both belong to the current request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmd <= '0;
        end else if (i_cmd.load_add) begin
            r_rmd <= '0;
        end else if (i_cmd.mod_step && (r_cnt == '0)) begin
            r_rmd <= n_rmd;
        end
    end

    // Bucket memory read port, registered.
    assign rd_addr = i_cmd.scan_rd ? r_cnt[IDX_W-1:0] : r_rmd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_bucket || i_cmd.scan_rd) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_valid[rd_addr];
        end
    end

    // Refreshed bucket for an add request.
    assign hit = r_rd_vld && (r_rd_data.day == r_req.day);

    always_comb begin
        upd = r_rd_data;
        if (!hit) begin
            upd.low   = r_req.reading_mv;
            upd.high  = r_req.reading_mv;
            upd.sum   = BKT_SUM_W'(r_req.reading_mv);
            upd.count = BKT_CNT_W'(1);
            upd.day   = r_req.day;
        end else begin
            if (r_req.reading_mv < r_rd_data.low) begin
                upd.low = r_req.reading_mv;
            end
            if (r_req.reading_mv > r_rd_data.high) begin
                upd.high = r_req.reading_mv;
            end
            if (r_rd_data.count != BKT_CNT_MAX) begin
                upd.sum   = r_rd_data.sum + BKT_SUM_W'(r_req.reading_mv);
                upd.count = r_rd_data.count + 1'b1;
            end
        end
    end

    // Bucket memory write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_bucket) begin
            mem[r_rmd] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr_bucket) begin
            r_valid[r_rmd] <= 1'b1;
        end
    end

    // Scan accumulation, in the cycle after each read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_cmd.load_query) begin
            r_seen <= 1'b0;
        end else if (r_acc_en && r_rd_vld) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_sum <= '0;
            r_tot <= '0;
        end else if (r_acc_en && r_rd_vld) begin
            if (!r_seen || r_rd_data.low < r_lo) begin
                r_lo <= r_rd_data.low;
            end
            if (!r_seen || r_rd_data.high > r_hi) begin
                r_hi <= r_rd_data.high;
            end
            r_sum <= r_sum + SUM_W'(r_rd_data.sum);
            r_tot <= r_tot + TOT_W'(r_rd_data.count);
        end
    end

    // Restoring divider: the average fits in MV_W bits, so only that many steps.
    assign div_t  = {r_rem, r_qd[MV_W-1]};
    assign div_ge = (div_t >= {1'b0, r_tot});
    assign n_rem  = div_ge ? TOT_W'(div_t - {1'b0, r_tot}) : div_t[TOT_W-1:0];
    assign n_qd   = {r_qd[MV_W-2:0], div_ge};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= r_sum[SUM_W-1:MV_W];
            r_qd  <= r_sum[MV_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_qd  <= n_qd;
        end
    end

    // Result register; an empty window reports zeros.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_seen) begin
                r_res.window_low  <= r_lo;
                r_res.window_high <= r_hi;
                r_res.window_avg  <= r_qd;
            end else begin
                r_res <= '0;
            end
        end
    end

    assign o_res = r_res;

    // The bucket index never reaches the bucket count.
    a_rmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rmd < N_MOD[IDX_W-1:0] || N_MOD[IDX_W])
        else $error("bucket index out of range");

    // Once anything is seen, the window low cannot exceed the window high.
    a_lo_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen && !r_acc_en) |-> (r_lo <= r_hi))
        else $error("window low above window high");

    // The partial remainder stays below the divisor during division.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && r_seen) |-> (r_rem < r_tot))
        else $error("divider remainder not below divisor");

endmodule

// ===== rtl/day_bucket_min_max_avg_stats.sv =====
// Top level of the day-bucket battery statistics block.
// Depends on dbs_pkg, dbs_ctrl and dbs_dp.
//
//  Channel   Valid     Stall     Payload   Direction
//  request   i_valid   o_stall   i_req     in  (add reading or query)
//  result    o_valid   i_stall   o_res     out (one per query)
//
// An add steps through accept, the day modulo (fold, reciprocal
// multiply, remainder), read and write.
// A query steps through accept, one bucket read per cycle,
// a drain step, the bit-serial divider, then the result register load.
// Reset clears the bucket valid flags at once, so no clearing pass is needed.
// The result sits in its own register; a stalled result holds a later query at its
// final load, and the request channel stays stalled until that load is done.
module day_bucket_min_max_avg_stats import dbs_pkg::*; #(
    parameter int NUM_BUCKETS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer.
    dbs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_req_cmd (i_req.cmd),
        .i_stall   (i_stall),
        .i_sts     (dp_sts),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_cmd     (dp_cmd)
    );

    // Bucket store and arithmetic.
    dbs_dp #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .o_res   (o_res)
    );

endmodule
